@@ rtl/whdr_pkg.sv @@
// shared constants, codes and control/status types for the walk hash recorder
package whdr_pkg;

   // hash arithmetic
   localparam int          HASH_W    = 32;
   localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

   // field widths
   localparam int STEP_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   // reported count saturates here
   localparam int COUNT_MAX = 511;

   // default table size
   localparam int TABLE_DEPTH_DEF = 256;

   // request kinds
   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // record status codes
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic fold;        // fold the step byte into the running hash
      logic scan_start;  // clear the scan pointer
      logic scan_run;    // step the table scan
      logic rpt_dup;     // report a duplicate and restart the hash
      logic rpt_final;   // scan finished without a match: append or drop
      logic rpt_empty;   // report an empty walk
   } whdr_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic nonempty;    // current walk has at least one step
      logic hit;         // compared table entry matches the hash
      logic scan_done;   // every stored entry has been read
   } whdr_sts_type;

endpackage

@@ rtl/whdr_ram.sv @@
// generic single-clock ram, one write port and one registered read port
module whdr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/whdr_ctrl.sv @@
// control state machine: accepts transactions and sequences the table scan
module whdr_ctrl import whdr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_type,
   input  whdr_sts_type sts,
   output whdr_cmd_type cmd,
   output logic         busy
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_type == REQ_STEP) begin
                  cmd.fold = 1'b1;
               end else if (!sts.nonempty) begin
                  cmd.rpt_empty = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            priority if (sts.hit) begin
               cmd.rpt_dup = 1'b1;
               state_in    = S_IDLE;
            end else if (sts.scan_done) begin
               cmd.rpt_final = 1'b1;
               state_in      = S_IDLE;
            end else begin
               // keep reading entries
               state_in = S_SCAN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a finished scan always returns to idle
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && (sts.hit || sts.scan_done)) |=> (state_ff == S_IDLE))
      else $error("scan did not end after match or last entry");

   // a scan only begins on an end transaction of a walk with steps
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> (req_type == REQ_END && sts.nonempty))
      else $error("scan started without a nonempty walk end");

endmodule

@@ rtl/whdr_dp.sv @@
// datapath: running hash, seen-hash table, scan pointer and result registers
module whdr_dp import whdr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  whdr_cmd_type        cmd,
   input  logic [STEP_W-1:0]   req_step_id,
   output whdr_sts_type        sts,
   output logic                rsp_strobe,
   output logic [HASH_W-1:0]   rsp_walk_hash,
   output logic [STATUS_W-1:0] rsp_record_status,
   output logic [COUNT_W-1:0]  rsp_distinct_count
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic                nonempty_ff, nonempty_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [HASH_W-1:0]   rsp_hash_ff, rsp_hash_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [HASH_W-1:0]   fold_hash;
   logic [HASH_W-1:0]   rd_data;
   logic                more;
   logic                issue;
   logic                full;
   logic                append;
   logic                report;
   logic [CNT_W-1:0]    count_after;

   // fnv-1a byte fold
   assign fold_hash = (hash_ff ^ {{(HASH_W-STEP_W){1'b0}}, req_step_id}) * FNV_PRIME;

   // scan control
   assign more   = (scan_idx_ff < count_ff);
   assign issue  = cmd.scan_run && more;
   assign full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign append = cmd.rpt_final && !full;
   assign report = cmd.rpt_dup || cmd.rpt_final || cmd.rpt_empty;

   assign sts.nonempty  = nonempty_ff;
   assign sts.hit       = cmp_valid_ff && (rd_data == hash_ff);
   assign sts.scan_done = !more;

   // seen-hash table
   whdr_ram #(
      .WIDTH (HASH_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (append),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (hash_ff),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // next-state logic
   always_comb begin
      hash_in      = hash_ff;
      nonempty_in  = nonempty_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_valid_in = 1'b0;

      if (cmd.fold) begin
         hash_in     = fold_hash;
         nonempty_in = 1'b1;
      end
      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end else if (issue) begin
         scan_idx_in  = scan_idx_ff + CNT_W'(1);
         cmp_valid_in = 1'b1;
      end
      if (append) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (report) begin
         hash_in     = FNV_BASIS;
         nonempty_in = 1'b0;
      end
   end

   // result fields
   always_comb begin
      count_after   = append ? (count_ff + CNT_W'(1)) : count_ff;
      rsp_strobe_in = report;
      rsp_hash_in   = hash_ff;
      priority if (cmd.rpt_empty) begin
         rsp_status_in = ST_EMPTY;
      end else if (cmd.rpt_dup) begin
         rsp_status_in = ST_DUP;
      end else if (full) begin
         rsp_status_in = ST_FULL;
      end else begin
         rsp_status_in = ST_NEW;
      end
      if (32'(count_after) > 32'(COUNT_MAX)) begin
         rsp_count_in = COUNT_W'(COUNT_MAX);
      end else begin
         rsp_count_in = COUNT_W'(count_after);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff       <= FNV_BASIS;
         nonempty_ff   <= 1'b0;
         count_ff      <= '0;
         scan_idx_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         hash_ff       <= hash_in;
         nonempty_ff   <= nonempty_in;
         count_ff      <= count_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      if (report) begin
         rsp_hash_ff   <= rsp_hash_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_walk_hash      = rsp_hash_ff;
   assign rsp_record_status  = rsp_status_ff;
   assign rsp_distinct_count = rsp_count_ff;

   // table fill never passes its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // an append grows the count by exactly one
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      (!reset && append) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not advance entry count");

   // an empty walk always reports the offset basis
   a_empty_hash: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_record_status == ST_EMPTY) |-> (rsp_walk_hash == FNV_BASIS))
      else $error("empty walk reported a folded hash");

endmodule

@@ rtl/walk_hash_distinct_recorder_top.sv @@
// top level of the walk hash distinct recorder
//
// Step transactions (req_type 0) fold req_step_id into a running FNV-1a hash; busy stays
// low. An end transaction (req_type 1) of a walk with steps compares the hash against the
// stored table one entry per cycle through the table ram's single read port, with busy high
// until a match turns up or every entry has been compared; an end of an empty walk leaves
// busy low. Each end transaction gives one result, shown for one cycle with rsp_strobe in
// the first cycle that busy is low again (the cycle right after the accept for an empty
// walk). The receiver cannot stall and must take every strobe. New hashes are kept until
// TABLE_DEPTH entries are held; later new hashes are dropped with status 2.
// rsp_distinct_count saturates at 511. No clearing pass is needed after reset.
module walk_hash_distinct_recorder_top import whdr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  logic [STEP_W-1:0]   req_step_id,
   output logic                rsp_strobe,
   output logic [HASH_W-1:0]   rsp_walk_hash,
   output logic [STATUS_W-1:0] rsp_record_status,
   output logic [COUNT_W-1:0]  rsp_distinct_count
);

   whdr_cmd_type cmd;
   whdr_sts_type sts;

   // controller
   whdr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // datapath
   whdr_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_step_id        (req_step_id),
      .sts                (sts),
      .rsp_strobe         (rsp_strobe),
      .rsp_walk_hash      (rsp_walk_hash),
      .rsp_record_status  (rsp_record_status),
      .rsp_distinct_count (rsp_distinct_count)
   );

   // a result is always shown with the block ready for the next transaction
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

endmodule
